[hw/rtl/rr_pkg.sv]
// rr_pkg: shared types and constants for the reflection resolution block.
// Holds register indexes, status codes and the shared square-root step.
// No dependencies.
package rr_pkg;

  localparam int COEF_BITS = 48;
  localparam int NUM_COEF  = 6;
  localparam int CIDX_BITS = 3;
  localparam int OUT_BITS  = 32;
  localparam int SQ_RAD    = 64;
  localparam int SQ_REM    = 35;
  localparam int DIV_STEPS = 77;   // quotient bits of 2^76 / F
  localparam int SQ_STEPS  = 32;   // root bits of a 64-bit radicand

  // Configuration register indexes
  typedef enum logic [CIDX_BITS-1:0] {
    REG_HH = 3'd0,
    REG_KK = 3'd1,
    REG_LL = 3'd2,
    REG_HK = 3'd3,
    REG_KL = 3'd4,
    REG_HL = 3'd5
  } reg_idx_e;

  // Result status codes
  typedef enum logic [1:0] {
    ST_VALID    = 2'd0,
    ST_ZERO_IDX = 2'd1,
    ST_NOT_POS  = 2'd2
  } status_e;

  // Digit-by-digit square root context
  typedef struct packed {
    logic [SQ_RAD-1:0]   rad;
    logic [SQ_REM-1:0]   rem;
    logic [OUT_BITS-1:0] root;
  } sq_t;

  // One root bit: bring down two radicand bits, try 4*root+1
  function automatic sq_t sq_step(sq_t x);
    logic [SQ_REM-1:0] r2;
    logic [SQ_REM-1:0] t;
    sq_t               y;
    r2    = {x.rem[SQ_REM-3:0], x.rad[SQ_RAD-1 -: 2]};
    t     = {1'b0, x.root, 2'b01};
    y.rad = {x.rad[SQ_RAD-3:0], 2'b00};
    if (r2 >= t) begin
      y.rem  = r2 - t;
      y.root = {x.root[OUT_BITS-2:0], 1'b1};
    end else begin
      y.rem  = r2;
      y.root = {x.root[OUT_BITS-2:0], 1'b0};
    end
    return y;
  endfunction

endpackage

[hw/rtl/rr_fifo.sv]
// rr_fifo: small register queue between the front and back pipelines.
// Depends on nothing but its parameters.
module rr_fifo #(
  parameter int Width = 8,
  parameter int Depth = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o
);

  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;

  logic [Width-1:0] mem_q [Depth];
  logic [AW-1:0]    wr_q, wr_d, rd_q, rd_d;
  logic [AW:0]      cnt_q, cnt_d;

  assign full_o  = (cnt_q == (AW+1)'(Depth));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_q];

  // pointer and fill count update
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == AW'(Depth-1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == AW'(Depth-1)) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // storage, no reset
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

[hw/rtl/rr_front.sv]
// rr_front: accepts index triples, evaluates the reciprocal-metric form F
// and classifies the item. Six-stage pipeline. Uses rr_pkg.
module rr_front import rr_pkg::*; #(
  parameter int IndexBits = 10,
  parameter int FormBits  = COEF_BITS + 2*IndexBits + 3
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  logic                                acc_i,
  input  logic signed [IndexBits-1:0]         h_i,
  input  logic signed [IndexBits-1:0]         k_i,
  input  logic signed [IndexBits-1:0]         l_i,
  input  logic [NUM_COEF-1:0][COEF_BITS-1:0]  coef_i,
  output logic                                vld_o,
  output status_e                             status_o,
  output logic [FormBits-1:0]                 form_o
);

  localparam int PW     = 2*IndexBits;
  localparam int HALF   = COEF_BITS/2;
  localparam int PPW    = HALF + PW;
  localparam int TW     = COEF_BITS + PW;
  localparam int NSTAGE = 6;

  logic [NSTAGE-1:0] v_q;
  logic              z_q [NSTAGE];

  logic signed [IndexBits-1:0] h_q, k_q, l_q;
  logic signed [PW-1:0]        p_q   [NUM_COEF];
  logic signed [PPW-1:0]       plo_q [NUM_COEF];
  logic signed [PPW-1:0]       phi_q [NUM_COEF];
  logic signed [TW-1:0]        t_q   [NUM_COEF];
  logic signed [TW:0]          s_q   [3];
  logic signed [FormBits-1:0]  f_q;

  // valid and zero-index flags travel with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[NSTAGE-2:0], acc_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      z_q[0] <= (h_i == '0) && (k_i == '0) && (l_i == '0);
      for (int i = 1; i < NSTAGE; i++) begin
        z_q[i] <= z_q[i-1];
      end
    end
  end

  // index registers, then index products
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      h_q <= h_i;
      k_q <= k_i;
      l_q <= l_i;
      p_q[REG_HH] <= h_q * h_q;
      p_q[REG_KK] <= k_q * k_q;
      p_q[REG_LL] <= l_q * l_q;
      p_q[REG_HK] <= h_q * k_q;
      p_q[REG_KL] <= k_q * l_q;
      p_q[REG_HL] <= h_q * l_q;
    end
  end

  // coefficient split into two halves: partial products, then terms
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < NUM_COEF; i++) begin
        plo_q[i] <= $signed({1'b0, coef_i[i][HALF-1:0]}) * p_q[i];
        phi_q[i] <= $signed(coef_i[i][COEF_BITS-1:HALF]) * p_q[i];
        t_q[i]   <= {phi_q[i], {HALF{1'b0}}}
                    + {{HALF{plo_q[i][PPW-1]}}, plo_q[i]};
      end
    end
  end

  // two-level adder tree
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        s_q[i] <= {t_q[2*i][TW-1], t_q[2*i]} + {t_q[2*i+1][TW-1], t_q[2*i+1]};
      end
      f_q <= {{2{s_q[0][TW]}}, s_q[0]} + {{2{s_q[1][TW]}}, s_q[1]}
             + {{2{s_q[2][TW]}}, s_q[2]};
    end
  end

  // classification
  always_comb begin
    if (z_q[NSTAGE-1]) begin
      status_o = ST_ZERO_IDX;
    end else if (f_q[FormBits-1] || (f_q == '0)) begin
      status_o = ST_NOT_POS;
    end else begin
      status_o = ST_VALID;
    end
  end

  assign vld_o  = v_q[NSTAGE-1];
  assign form_o = f_q;

endmodule

[hw/rtl/rr_back.sv]
// rr_back: square root for sin(theta)/lambda, restoring division 2^76/F and
// square root for the d-spacing, one bit per stage, ending in the output register.
// Uses rr_pkg.
module rr_back import rr_pkg::*; #(
  parameter int FormBits = 71
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                vld_i,
  input  status_e             status_i,
  input  logic [FormBits-1:0] form_i,
  output logic                vld_o,
  output logic [OUT_BITS-1:0] stol_o,
  output logic [OUT_BITS-1:0] spacing_o,
  output status_e             status_o
);

  localparam int NS = DIV_STEPS + SQ_STEPS;

  typedef struct packed {
    status_e             st;
    logic                sat_a;
    logic                sat_b;
    logic [FormBits-1:0] f;
    logic [FormBits-1:0] drem;
    logic [SQ_RAD-1:0]   q;
    sq_t                 a;
    sq_t                 b;
  } bstage_t;

  logic [NS-1:0] v_q;
  bstage_t       pl_q [NS];
  bstage_t       pl_d [NS];
  bstage_t       init;
  logic [127:0]  fz;

  // entry: saturation tests and root initialization
  always_comb begin
    fz         = 128'(form_i);
    init.st    = status_i;
    init.sat_a = (fz >= (128'd1 << 62));
    init.sat_b = (fz <= 128'd4096);
    init.f     = form_i;
    init.drem  = '0;
    init.q     = '0;
    init.a     = '{rad: {fz[61:0], 2'b00}, rem: '0, root: '0};
    init.b     = '0;
  end

  // one step of each running recurrence per stage
  for (genvar s = 0; s < NS; s++) begin : g_stage
    always_comb begin
      logic [FormBits-1:0] rsh;
      bstage_t             x;
      x   = (s == 0) ? init : pl_q[(s == 0) ? 0 : s-1];
      rsh = '0;
      if (s < DIV_STEPS) begin
        rsh = {x.drem[FormBits-2:0], (s == 0) ? 1'b1 : 1'b0};
        if (rsh >= x.f) begin
          x.drem = rsh - x.f;
          x.q    = {x.q[SQ_RAD-2:0], 1'b1};
        end else begin
          x.drem = rsh;
          x.q    = {x.q[SQ_RAD-2:0], 1'b0};
        end
        if (s == DIV_STEPS-1) begin
          x.b = '{rad: x.q, rem: '0, root: '0};
        end
      end else begin
        x.b = sq_step(x.b);
      end
      if (s < SQ_STEPS) begin
        x.a = sq_step(x.a);
      end
      pl_d[s] = x;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[NS-2:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < NS; i++) begin
        pl_q[i] <= pl_d[i];
      end
    end
  end

  // output register is the last stage
  assign vld_o     = v_q[NS-1];
  assign status_o  = pl_q[NS-1].st;
  assign stol_o    = (pl_q[NS-1].st != ST_VALID) ? '0 :
                     pl_q[NS-1].sat_a ? '1 : pl_q[NS-1].a.root;
  assign spacing_o = (pl_q[NS-1].st != ST_VALID) ? '0 :
                     pl_q[NS-1].sat_b ? '1 : pl_q[NS-1].b.root;

endmodule

[hw/rtl/reflection_resolution.sv]
// reflection_resolution: top level, coefficient registers and the
// front / queue / back split. Uses rr_pkg, rr_front, rr_fifo and rr_back.
//
// Takes one Miller index triple per beat and returns sin(theta)/lambda
// (Q8.24) and the d-spacing (Q16.16) from the six Q4.44 reciprocal-metric
// coefficients. One item per cycle is sustained, but a stalled output holds
// the back pipeline; the four-entry queue lets the front keep accepting until
// it fills. The form takes six front stages, then the queue and 109 back
// stages (77 division bits then 32 root bits, one per stage, the last being
// the output register). Coefficients are written through the configuration
// beat (always ready); the user must do so only while idle (not enforced).
module reflection_resolution import rr_pkg::*; #(
  parameter int INDEX_BITS = 10
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [CIDX_BITS-1:0]        cfg_index_i,
  input  logic [COEF_BITS-1:0]        cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic signed [INDEX_BITS-1:0] index_h_i,
  input  logic signed [INDEX_BITS-1:0] index_k_i,
  input  logic signed [INDEX_BITS-1:0] index_l_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [OUT_BITS-1:0]         stol_o,
  output logic [OUT_BITS-1:0]         spacing_o,
  output logic [1:0]                  status_o
);

  localparam int FormBits = COEF_BITS + 2*INDEX_BITS + 3;
  localparam int QW       = FormBits + 2;

  logic [NUM_COEF-1:0][COEF_BITS-1:0] coef_q;
  logic                en_f, en_b, f_vld, q_full, q_empty, push, pop;
  status_e             f_st, b_st_in, o_st;
  logic [FormBits-1:0] f_form, b_form;
  logic [QW-1:0]       q_in, q_out;

  // coefficient registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_HH:  coef_q[REG_HH] <= cfg_data_i;
        REG_KK:  coef_q[REG_KK] <= cfg_data_i;
        REG_LL:  coef_q[REG_LL] <= cfg_data_i;
        REG_HK:  coef_q[REG_HK] <= cfg_data_i;
        REG_KL:  coef_q[REG_KL] <= cfg_data_i;
        REG_HL:  coef_q[REG_HL] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // front stalls only when its last stage cannot enter the queue
  assign en_f       = !(f_vld && q_full);
  assign in_stall_o = !en_f;
  assign push       = f_vld && !q_full;

  rr_front #(
    .IndexBits (INDEX_BITS),
    .FormBits  (FormBits)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en_f),
    .acc_i    (in_valid_i),
    .h_i      (index_h_i),
    .k_i      (index_k_i),
    .l_i      (index_l_i),
    .coef_i   (coef_q),
    .vld_o    (f_vld),
    .status_o (f_st),
    .form_o   (f_form)
  );

  assign q_in = {f_st, f_form};

  rr_fifo #(
    .Width (QW),
    .Depth (4)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (q_in),
    .full_o  (q_full),
    .pop_i   (pop),
    .data_o  (q_out),
    .empty_o (q_empty)
  );

  // back advances whenever the output register is free or being taken
  assign en_b    = !out_valid_o || !out_stall_i;
  assign pop     = en_b && !q_empty;
  assign b_st_in = status_e'(q_out[QW-1 -: 2]);
  assign b_form  = q_out[FormBits-1:0];

  rr_back #(
    .FormBits (FormBits)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en_b),
    .vld_i     (!q_empty),
    .status_i  (b_st_in),
    .form_i    (b_form),
    .vld_o     (out_valid_o),
    .stol_o    (stol_o),
    .spacing_o (spacing_o),
    .status_o  (o_st)
  );

  assign status_o = o_st;

endmodule
